[rtl/rwlt_pkg.sv]
// Shared types, constants and helpers of the reader-writer lock table.
package rwlt_pkg;

   localparam int NUM_LOCKS   = 512;
   localparam int READER_BITS = 31;

   localparam int OP_W      = 2;
   localparam int INDEX_W   = 9;
   localparam int STATUS_W  = 2;
   localparam int READERS_W = 31;

   localparam int WORD_W = READER_BITS + 1;
   localparam int ADDR_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [READER_BITS-1:0] count_type;

   localparam word_type WRITER_FLAG = word_type'(1) << READER_BITS;

   typedef enum logic [OP_W-1:0] {
      OP_TRY_READ     = 2'd0,
      OP_UNLOCK_READ  = 2'd1,
      OP_TRY_WRITE    = 2'd2,
      OP_UNLOCK_WRITE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REFUSED  = 2'd1,
      STATUS_NOT_HELD = 2'd2
   } status_type;

   // Decision for one request, passed from the update logic to the pipeline.
   typedef struct packed {
      logic       granted;
      status_type status;
      logic       write_en;
      word_type   word_next;
   } upd_result_type;

   // Reader count as it is reported on the result channel.
   function automatic logic [READERS_W-1:0] to_readers(input count_type count);
      logic [63:0] wide;
      wide = 64'(count);
      return wide[READERS_W-1:0];
   endfunction

endpackage

[rtl/rwlt_if.sv]
// Valid-ready channel interfaces for lock requests and their results.
interface rwlt_req_if;
   import rwlt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [INDEX_W-1:0] lock_index;

   modport source (output valid, output operation, output lock_index, input ready);
   modport sink   (input valid, input operation, input lock_index, output ready);
endinterface

interface rwlt_rsp_if;
   import rwlt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [STATUS_W-1:0]  status;
   logic [READERS_W-1:0] readers_after;
   logic                 writer_after;

   modport source (output valid, output granted, output status, output readers_after,
                   output writer_after, input ready);
   modport sink   (input valid, input granted, input status, input readers_after,
                   input writer_after, output ready);
endinterface

[rtl/rwlt_lock_ram.sv]
// Single-port-write, single-port-read memory with a registered read.
module rwlt_lock_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/rwlt_update.sv]
// Lock word update: decides grant and status and forms the new word.
module rwlt_update (
   input  rwlt_pkg::op_type         operation,
   input  logic                     in_range,
   input  rwlt_pkg::word_type       word,
   output rwlt_pkg::upd_result_type result
);
   import rwlt_pkg::*;

   count_type count;
   logic      wbit;
   logic      full;

   assign count = word[READER_BITS-1:0];
   assign wbit  = word[READER_BITS];
   assign full  = &count;

   always_comb begin
      result.granted   = 1'b0;
      result.status    = STATUS_OK;
      result.write_en  = 1'b0;
      result.word_next = word;
      if (!in_range) begin
         // No state touched; the reported word is zero.
         result.word_next = '0;
         if (operation == OP_TRY_READ || operation == OP_TRY_WRITE) begin
            result.status = STATUS_REFUSED;
         end else begin
            result.status = STATUS_NOT_HELD;
         end
      end else begin
         unique case (operation)
            OP_TRY_READ: begin
               if (!wbit && !full) begin
                  result.word_next = word + word_type'(1);
                  result.granted   = 1'b1;
                  result.write_en  = 1'b1;
               end else begin
                  result.status = STATUS_REFUSED;
               end
            end
            OP_UNLOCK_READ: begin
               if (count != '0) begin
                  result.word_next = word - word_type'(1);
                  result.granted   = 1'b1;
                  result.write_en  = 1'b1;
               end else begin
                  result.status = STATUS_NOT_HELD;
               end
            end
            OP_TRY_WRITE: begin
               if (word == '0) begin
                  result.word_next = WRITER_FLAG;
                  result.granted   = 1'b1;
                  result.write_en  = 1'b1;
               end else begin
                  result.status = STATUS_REFUSED;
               end
            end
            OP_UNLOCK_WRITE: begin
               if (wbit) begin
                  result.word_next = word & ~WRITER_FLAG;
                  result.granted   = 1'b1;
                  result.write_en  = 1'b1;
               end else begin
                  result.status = STATUS_NOT_HELD;
               end
            end
            default: begin
               result.status = STATUS_NOT_HELD;
            end
         endcase
      end
   end
endmodule

[rtl/reader_writer_lock_table_core.sv]
// Top level of the reader-writer lock table.
//
// The block keeps a table of NUM_LOCKS reader-writer lock words in one
// synchronous memory. Each word holds a writer bit above a reader count.
// Every request item names an operation (try read, unlock read, try write,
// unlock write) and a lock, and produces exactly one result item that tells
// whether the request was granted, a status (ok, refused because the lock is
// busy, the reader count is full or the lock is out of range, or unlock of a
// lock that is not held or out of range), and the lock's reader count and
// writer bit after the request. After reset the block sweeps the memory to
// zero, one word per cycle; no request is accepted during that sweep. After
// it the block takes one request per cycle while its results are taken. A
// request accepted at a clock edge reads its lock word from the memory at
// that edge into the decide stage; there it is decided and written back,
// and its result is loaded into the result register, once that register is
// free or being taken. The word written by one request is forwarded from a
// bypass register to the next request that reads the same lock, so
// back-to-back requests to one lock see each other's updates.
// A result register parts the two channels: while a result waits to be
// taken, the next request can already have read its lock word.
module reader_writer_lock_table_core (
   input logic       clock,
   input logic       reset,
   rwlt_req_if.sink  req_if,
   rwlt_rsp_if.source rsp_if
);
   import rwlt_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // Sweep control.
   state_type st_ff, st_in;
   addr_type  clr_cnt_ff, clr_cnt_in;

   // Decide stage: the request whose word is being read.
   logic     s1_valid_ff, s1_valid_in;
   op_type   s1_op_ff;
   logic     s1_in_range_ff;
   addr_type s1_addr_ff;

   // Bypass of the most recent write back.
   logic     byp_valid_ff, byp_valid_in;
   addr_type byp_addr_ff;
   word_type byp_word_ff;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff;
   status_type           rsp_status_ff;
   logic [READERS_W-1:0] rsp_readers_ff;
   logic                 rsp_writer_ff;

   logic           req_accept;
   logic           s1_fire;
   logic           req_in_range;
   word_type       ram_rd_data;
   word_type       cur_word;
   upd_result_type upd;
   logic           ram_wr_en;
   addr_type       ram_wr_addr;
   word_type       ram_wr_data;
   logic           upd_write;

   // The decide stage moves on when the result register is free or being taken.
   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (st_ff == ST_RUN) && (!s1_valid_ff || s1_fire);
   assign req_accept   = req_if.valid && req_if.ready;
   assign req_in_range = 32'(req_if.lock_index) < NUM_LOCKS;

   always_comb begin
      st_in      = st_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + addr_type'(1);
            if (clr_cnt_ff == addr_type'(NUM_LOCKS - 1)) begin
               st_in = ST_RUN;
            end
         end
         ST_RUN: begin
            st_in = ST_RUN;
         end
         default: begin
            st_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         st_ff      <= st_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // The bypass holds the last word written, so it is always the newest copy.
   assign cur_word = (byp_valid_ff && byp_addr_ff == s1_addr_ff) ? byp_word_ff : ram_rd_data;

   rwlt_update u_update (
      .operation (s1_op_ff),
      .in_range  (s1_in_range_ff),
      .word      (cur_word),
      .result    (upd)
   );

   assign upd_write = s1_fire && upd.write_en;

   always_comb begin
      if (st_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = upd_write;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = upd.word_next;
      end
   end

   rwlt_lock_ram #(
      .DEPTH (NUM_LOCKS),
      .WIDTH (WORD_W)
   ) u_lock_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (addr_type'(req_if.lock_index)),
      .rd_data (ram_rd_data)
   );

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign byp_valid_in = (st_ff == ST_RUN) && (byp_valid_ff || upd_write);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= op_type'(req_if.operation);
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= addr_type'(req_if.lock_index);
      end
      if (upd_write) begin
         byp_addr_ff <= s1_addr_ff;
         byp_word_ff <= upd.word_next;
      end
      if (s1_fire) begin
         rsp_granted_ff <= upd.granted;
         rsp_status_ff  <= upd.status;
         rsp_readers_ff <= to_readers(upd.word_next[READER_BITS-1:0]);
         rsp_writer_ff  <= upd.word_next[READER_BITS];
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.granted       = rsp_granted_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.readers_after = rsp_readers_ff;
   assign rsp_if.writer_after  = rsp_writer_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR) |-> !req_if.ready)
      else $error("request accepted during the clearing sweep");

   a_no_write_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_in_range_ff) |-> !upd.write_en)
      else $error("out-of-range request would write the table");

   a_grant_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_granted_ff == (rsp_status_ff == STATUS_OK)))
      else $error("granted and status disagree");

   a_bypass_after_write: assert property (@(posedge clock) disable iff (reset)
      (upd_write && st_ff == ST_RUN) |=> (byp_valid_ff && byp_word_ff == $past(upd.word_next)))
      else $error("bypass register missed a write back");

   a_try_write_word: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && upd.write_en && s1_op_ff == OP_TRY_WRITE)
         |-> (upd.word_next == WRITER_FLAG))
      else $error("granted try-write left readers in the word");
`endif
endmodule

[test/lock_table_checker.sv]
// Checker that predicts every result item of the lock table and compares it with the DUT.
`timescale 1ns / 100ps
module lock_table_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [rwlt_pkg::OP_W-1:0]      req_operation,
   input  logic [rwlt_pkg::INDEX_W-1:0]   req_lock_index,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_granted,
   input  logic [rwlt_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [rwlt_pkg::READERS_W-1:0] rsp_readers_after,
   input  logic                           rsp_writer_after,
   output int                             fail_count,
   output int                             pending
);
   import rwlt_pkg::*;

   typedef struct packed {
      logic                 granted;
      status_type           status;
      logic [READERS_W-1:0] readers_after;
      logic                 writer_after;
   } lock_result_type;

   word_type        lock_words_model [NUM_LOCKS];
   lock_result_type expected_results [$];

   task automatic report_failure(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Applies one request to the model table and returns the result it earns.
   function automatic lock_result_type apply_lock_request(input op_type op,
                                                          input logic [INDEX_W-1:0] index);
      lock_result_type result;
      word_type        word;
      count_type       count;
      logic            writer;
      result = '0;
      if (int'(index) >= NUM_LOCKS) begin
         if (op == OP_TRY_READ || op == OP_TRY_WRITE) begin
            result.status = STATUS_REFUSED;
         end else begin
            result.status = STATUS_NOT_HELD;
         end
         return result;
      end
      word   = lock_words_model[index];
      count  = word[READER_BITS-1:0];
      writer = word[READER_BITS];
      result.status = STATUS_OK;
      case (op)
         OP_TRY_READ: begin
            if (!writer && count != '1) begin
               word = word + word_type'(1);
               result.granted = 1'b1;
            end else begin
               result.status = STATUS_REFUSED;
            end
         end
         OP_UNLOCK_READ: begin
            if (count != '0) begin
               word = word - word_type'(1);
               result.granted = 1'b1;
            end else begin
               result.status = STATUS_NOT_HELD;
            end
         end
         OP_TRY_WRITE: begin
            if (word == '0) begin
               word = WRITER_FLAG;
               result.granted = 1'b1;
            end else begin
               result.status = STATUS_REFUSED;
            end
         end
         default: begin
            if (writer) begin
               word = word & ~WRITER_FLAG;
               result.granted = 1'b1;
            end else begin
               result.status = STATUS_NOT_HELD;
            end
         end
      endcase
      lock_words_model[index] = word;
      result.readers_after = READERS_W'(word[READER_BITS-1:0]);
      result.writer_after  = word[READER_BITS];
      return result;
   endfunction

   always @(posedge clock) begin
      lock_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) lock_words_model[i] = '0;
         expected_results.delete();
      end else begin
         // A result taken at this edge belongs to an older request, so it is
         // checked before the request taken at the same edge is queued.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_failure("result item with no request waiting");
            end else begin
               want = expected_results.pop_front();
               if (rsp_granted !== want.granted)
                  report_failure($sformatf("granted: expected %0d, got %0d",
                                           want.granted, rsp_granted));
               if (rsp_status !== want.status)
                  report_failure($sformatf("status: expected %0d, got %0d",
                                           want.status, rsp_status));
               if (rsp_readers_after !== want.readers_after)
                  report_failure($sformatf("readers_after: expected %0d, got %0d",
                                           want.readers_after, rsp_readers_after));
               if (rsp_writer_after !== want.writer_after)
                  report_failure($sformatf("writer_after: expected %0d, got %0d",
                                           want.writer_after, rsp_writer_after));
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_lock_request(op_type'(req_operation),
                                                          req_lock_index));
      end
      pending = expected_results.size();
   end

endmodule

[test/tb_reader_writer_lock_table_core.sv]
// Testbench top of the lock table: request stimulus, result back-pressure, watchdog, verdict.
`timescale 1ns / 100ps
module tb_reader_writer_lock_table_core;
   import rwlt_pkg::*;

   // The random part stops after about this many request items.
   localparam int RANDOM_ITEMS = 700;
   // The longest quiet stretch of a correct run is the clearing sweep after
   // reset (one word per cycle) plus a few cycles; this is several times that.
   localparam int IDLE_LIMIT   = 2000;
   // The result of a request is held in the result register once it is decided; this leaves margin.
   localparam int DRAIN_CYCLES = 8;
   // Most random requests go to a handful of locks so that their words
   // move through many states instead of staying free.
   localparam int HOT_LOCKS    = 6;
   // The sender waits for every outstanding result this often.
   localparam int PAUSE_EVERY  = 200;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   int   gap_free_items = 0;
   logic [INDEX_W-1:0] hot_locks [HOT_LOCKS];

   rwlt_req_if req_ch();
   rwlt_rsp_if rsp_ch();

   reader_writer_lock_table_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // The checker sees both channels, keeps its own lock table and reports
   // every mismatch; the top only reads its failure and pending counts.
   lock_table_checker lock_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_operation     (req_ch.operation),
      .req_lock_index    (req_ch.lock_index),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_granted       (rsp_ch.granted),
      .rsp_status        (rsp_ch.status),
      .rsp_readers_after (rsp_ch.readers_after),
      .rsp_writer_after  (rsp_ch.writer_after),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle gaps are mostly absent or short, with an occasional long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 10) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request item and holds it until the block takes it. Valid is
   // only lowered when a gap follows, so back-to-back items keep it high.
   task automatic send_request(input op_type op, input logic [INDEX_W-1:0] index);
      int gap;
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.lock_index <= index;
      do @(posedge clock); while (!req_ch.ready);
      if (gap_free_items > 0) begin
         gap_free_items--;
         gap = 0;
      end else begin
         gap = pick_gap();
         // Now and then a run of items goes out with no gaps at all.
         if ($urandom_range(0, 29) == 0) gap_free_items = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender off until every result item so far has been taken.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // The result side alternates between stretches of ready and stalls. Some
   // stretches are long, so that the block also runs with no back-pressure.
   initial begin
      int stall;
      forever begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(40, 120)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watchdog: a run that takes no item on either side for too long is hung.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_reader_writer_lock_table_core failed");
         $finish;
      end
   end

   initial begin
      int sent;
      int next_pause;
      int choice;
      int burst;
      logic [INDEX_W-1:0] index;

      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_TRY_READ;
      req_ch.lock_index <= '0;
      reset             <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Lock 0 walks through shared ownership: two readers,
      // a writer refused while they hold it, a bad write unlock, both
      // readers leaving and one reader unlock too many.
      send_request(OP_TRY_READ,     9'd0);
      send_request(OP_TRY_READ,     9'd0);
      send_request(OP_TRY_WRITE,    9'd0);
      send_request(OP_UNLOCK_WRITE, 9'd0);
      send_request(OP_UNLOCK_READ,  9'd0);
      send_request(OP_UNLOCK_READ,  9'd0);
      send_request(OP_UNLOCK_READ,  9'd0);
      // The highest lock is held by a writer: readers and a second writer
      // are refused, a reader unlock finds no reader, and the writer bit
      // can be released only once.
      send_request(OP_TRY_WRITE,    9'd511);
      send_request(OP_TRY_READ,     9'd511);
      send_request(OP_TRY_WRITE,    9'd511);
      send_request(OP_UNLOCK_READ,  9'd511);
      send_request(OP_UNLOCK_WRITE, 9'd511);
      send_request(OP_UNLOCK_WRITE, 9'd511);
      // Two locks with alternating index bits, one held for writing and one
      // for reading, interleaved so that neighbors do not disturb each other.
      send_request(OP_TRY_WRITE,    9'h155);
      send_request(OP_TRY_READ,     9'h0AA);
      send_request(OP_TRY_WRITE,    9'h0AA);
      send_request(OP_TRY_READ,     9'h155);
      send_request(OP_UNLOCK_WRITE, 9'h155);
      send_request(OP_UNLOCK_READ,  9'h0AA);
      send_request(OP_TRY_WRITE,    9'h0AA);
      wait_for_results();

      // Random part.
      for (int i = 0; i < HOT_LOCKS; i++)
         hot_locks[i] = INDEX_W'($urandom_range(0, NUM_LOCKS - 1));
      sent       = 0;
      next_pause = PAUSE_EVERY;
      while (sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 9);
         index  = hot_locks[$urandom_range(0, HOT_LOCKS - 1)];
         if (choice < 2) begin
            // A group of readers shares a lock and then leaves, sometimes
            // with one unlock too many.
            burst = $urandom_range(2, 20);
            repeat (burst) send_request(OP_TRY_READ, index);
            if ($urandom_range(0, 3) == 0) burst++;
            repeat (burst) send_request(OP_UNLOCK_READ, index);
            sent += 2 * burst;
         end else if (choice < 4) begin
            // A writer's critical section, with a reader trying to get in.
            send_request(OP_TRY_WRITE, index);
            send_request(OP_TRY_READ, index);
            send_request(OP_UNLOCK_WRITE, index);
            sent += 3;
         end else if (choice < 8) begin
            // Any operation on a hot lock, which also breaks the sequences.
            send_request(op_type'($urandom_range(0, 3)), index);
            sent++;
         end else begin
            // Any operation on any lock, to spread the index bits.
            send_request(op_type'($urandom_range(0, 3)),
                         INDEX_W'($urandom_range(0, NUM_LOCKS - 1)));
            sent++;
         end
         if (sent >= next_pause) begin
            wait_for_results();
            next_pause += PAUSE_EVERY;
         end
      end

      // Drain every outstanding result, then give the pipeline a few more
      // cycles so that a stray extra result item would still be seen.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_reader_writer_lock_table_core passed");
      end else begin
         $display("tb_reader_writer_lock_table_core failed");
      end
      $finish;
   end

endmodule
